[src/d2p_pkg.sv]
package d2p_pkg;

    // pixel field widths
    localparam int COORD_BITS = 11;
    localparam int DISP_BITS  = 8;
    localparam int COLOR_BITS = 8;

    // fixed-point formats
    localparam int COORD_FRAC = 16;                  // Q16.16 coordinates
    localparam int W_FRAC     = 24;                  // Q8.24 denominator
    localparam int CFG_BITS   = 32;
    localparam int POINT_BITS = 32;

    // homogeneous numerator: col*2^16 plus a 32-bit offset, signed
    localparam int NH_BITS   = ((COORD_BITS + COORD_FRAC > CFG_BITS - 1) ?
                                (COORD_BITS + COORD_FRAC) : (CFG_BITS - 1)) + 2;
    // w_scale * disparity and W = product + w_offset, signed
    localparam int PROD_BITS = CFG_BITS + DISP_BITS;
    localparam int W_BITS    = PROD_BITS + 1;

    // quotient magnitude bits resolved by the divider, one per stage
    localparam int QUOT_BITS = POINT_BITS + 1;
    localparam int HI_SHIFT  = QUOT_BITS - W_FRAC;
    // divider latency: magnitude stage, init stage, step stages, clamp stage
    localparam int DIV_LAT   = QUOT_BITS + 3;

    localparam logic [DISP_BITS-1:0] MIN_DISP = DISP_BITS'(2);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOCAL        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_W_SCALE      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_W_OFFSET     = 3'd5;

    // clamp limits
    localparam logic signed [POINT_BITS-1:0] POINT_MAX = {1'b0, {(POINT_BITS-1){1'b1}}};
    localparam logic signed [POINT_BITS-1:0] POINT_MIN = {1'b1, {(POINT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DISP_BITS-1:0]  disparity;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic signed [POINT_BITS-1:0] point_x;
        logic signed [POINT_BITS-1:0] point_y;
        logic signed [POINT_BITS-1:0] point_z;
        logic [COLOR_BITS-1:0]        out_red;
        logic [COLOR_BITS-1:0]        out_green;
        logic [COLOR_BITS-1:0]        out_blue;
        logic                         saturated;
    } point_t;

    typedef struct packed {
        logic signed [NH_BITS-1:0] num;
        logic signed [W_BITS-1:0]  den;
    } div_in_t;

    typedef struct packed {
        logic signed [POINT_BITS-1:0] quot;
        logic                         clamped;
    } div_out_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  wzero;
    } side_t;

endpackage

[src/d2p_div.sv]
module d2p_div (
    input  logic               clk,
    input  logic               advance,
    input  d2p_pkg::div_in_t   din,
    output d2p_pkg::div_out_t  dout
);
    import d2p_pkg::*;

    // magnitude stage
    logic [NH_BITS-1:0] num_mag_reg;
    logic [W_BITS-1:0]  den_mag_reg;
    logic               neg_mag_reg;

    // per-stage state of the restoring division, index 0 is the init stage
    logic [W_BITS-1:0]    rem_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] low_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [0:QUOT_BITS];
    logic [W_BITS-1:0]    den_reg  [0:QUOT_BITS];
    logic                 neg_reg  [0:QUOT_BITS];
    logic                 ov_reg   [0:QUOT_BITS];

    logic [W_BITS-1:0]    rem_next  [1:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_next [1:QUOT_BITS];

    logic [NH_BITS-1:0] num_mag_next;
    logic [W_BITS-1:0]  den_mag_next;
    logic [W_BITS-1:0]  hi_next;
    logic               ov_next;

    div_out_t dout_reg;
    div_out_t dout_next;

    // absolute values and result sign
    always_comb
    begin
        num_mag_next = din.num[NH_BITS-1] ? NH_BITS'(-din.num) : NH_BITS'(din.num);
        den_mag_next = din.den[W_BITS-1] ? W_BITS'(-din.den) : W_BITS'(din.den);
    end

    // upper dividend bits: at least the divisor means the quotient needs more bits
    always_comb
    begin
        hi_next = W_BITS'(num_mag_reg >> HI_SHIFT);
        ov_next = (hi_next >= den_mag_reg);
    end

    // one quotient bit per stage
    always_comb
    begin
        logic [W_BITS:0] trial;
        for (int k = 1; k <= QUOT_BITS; k++)
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QUOT_BITS-1]};
            if (trial >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k]  = W_BITS'(trial - {1'b0, den_reg[k-1]});
                quot_next[k] = {quot_reg[k-1][QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = W_BITS'(trial);
                quot_next[k] = {quot_reg[k-1][QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    // sign and clamp to the point range
    always_comb
    begin
        logic [QUOT_BITS-1:0] q;
        q = quot_reg[QUOT_BITS];
        dout_next.clamped = 1'b0;
        dout_next.quot    = '0;
        if (ov_reg[QUOT_BITS])
        begin
            dout_next.clamped = 1'b1;
            dout_next.quot    = neg_reg[QUOT_BITS] ? POINT_MIN : POINT_MAX;
        end
        else if (!neg_reg[QUOT_BITS])
        begin
            if (q[QUOT_BITS-1] || q[QUOT_BITS-2])
            begin
                dout_next.clamped = 1'b1;
                dout_next.quot    = POINT_MAX;
            end
            else
            begin
                dout_next.quot = POINT_BITS'(q);
            end
        end
        else
        begin
            if (q > {1'b0, POINT_MIN})
            begin
                dout_next.clamped = 1'b1;
                dout_next.quot    = POINT_MIN;
            end
            else
            begin
                dout_next.quot = POINT_BITS'(-q);
            end
        end
    end

    // stage registers, all held on a stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_mag_reg <= num_mag_next;
            den_mag_reg <= den_mag_next;
            neg_mag_reg <= din.num[NH_BITS-1] ^ din.den[W_BITS-1];

            rem_reg[0]  <= hi_next;
            low_reg[0]  <= QUOT_BITS'({num_mag_reg, {W_FRAC{1'b0}}});
            quot_reg[0] <= '0;
            den_reg[0]  <= den_mag_reg;
            neg_reg[0]  <= neg_mag_reg;
            ov_reg[0]   <= ov_next;

            for (int k = 1; k <= QUOT_BITS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_reg[k-1][QUOT_BITS-2:0], 1'b0};
                quot_reg[k] <= quot_next[k];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ov_reg[k]   <= ov_reg[k-1];
            end

            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[src/disparity_to_point_reprojection_top.sv]
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------
// pixel in  | in_valid / in_ready        | in_data   (col, row, disparity, rgb)
// point out | out_valid / out_ready      | out_data  (point xyz, rgb, saturated)
// config    | cfg_we, cfg_index          | cfg_wdata (one register per write)
//
// one pixel enters per cycle unless out_ready stalls; its point passes stage a, stage b,
// the restoring divider and the output stage; one quotient bit per stage, three lanes
// rst_n is asynchronous and clears the valid bits and the configuration registers
// a stall on out_ready freezes the whole pipeline and drops in_ready in the same cycle
module disparity_to_point_reprojection_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  d2p_pkg::pixel_t                        in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output d2p_pkg::point_t                        out_data,
    input  logic                                   cfg_we,
    input  logic [d2p_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [d2p_pkg::CFG_BITS-1:0]           cfg_wdata
);
    import d2p_pkg::*;

    // configuration
    logic                       point_enable_reg;
    logic signed [CFG_BITS-1:0] x_offset_reg;
    logic signed [CFG_BITS-1:0] y_offset_reg;
    logic signed [CFG_BITS-1:0] focal_reg;
    logic signed [CFG_BITS-1:0] w_scale_reg;
    logic signed [CFG_BITS-1:0] w_offset_reg;

    logic advance;

    // stage a
    logic                        a_valid_reg;
    logic                        a_valid_next;
    logic signed [NH_BITS-1:0]   a_xh_reg;
    logic signed [NH_BITS-1:0]   a_yh_reg;
    logic signed [PROD_BITS-1:0] a_prod_reg;
    side_t                       a_side_reg;
    logic signed [NH_BITS-1:0]   a_xh_next;
    logic signed [NH_BITS-1:0]   a_yh_next;
    logic signed [PROD_BITS-1:0] ws_ext;
    logic signed [PROD_BITS-1:0] disp_ext;

    // stage b
    logic                       b_valid_reg;
    logic signed [NH_BITS-1:0]  b_xh_reg;
    logic signed [NH_BITS-1:0]  b_yh_reg;
    logic signed [NH_BITS-1:0]  b_zh_reg;
    logic signed [W_BITS-1:0]   b_w_reg;
    side_t                      b_side_reg;

    // sideband beside the dividers
    logic  c_valid_reg [1:DIV_LAT];
    side_t c_side_reg  [1:DIV_LAT];
    side_t c_side_next;

    div_in_t  div_x_in;
    div_in_t  div_y_in;
    div_in_t  div_z_in;
    div_out_t div_x_out;
    div_out_t div_y_out;
    div_out_t div_z_out;

    logic   out_valid_reg;
    point_t out_data_reg;
    point_t out_data_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_enable_reg <= 1'b0;
            x_offset_reg     <= '0;
            y_offset_reg     <= '0;
            focal_reg        <= '0;
            w_scale_reg      <= '0;
            w_offset_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_ENABLE: point_enable_reg <= cfg_wdata[0];
                REG_X_OFFSET:     x_offset_reg     <= cfg_wdata;
                REG_Y_OFFSET:     y_offset_reg     <= cfg_wdata;
                REG_FOCAL:        focal_reg        <= cfg_wdata;
                REG_W_SCALE:      w_scale_reg      <= cfg_wdata;
                REG_W_OFFSET:     w_offset_reg     <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // pipeline moves when the output register is empty or taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // stage a: numerators and the w_scale product; filtered pixels never enter
    always_comb
    begin
        a_valid_next = in_valid && point_enable_reg && (in_data.disparity >= MIN_DISP);
        a_xh_next    = NH_BITS'({in_data.col, {COORD_FRAC{1'b0}}}) + NH_BITS'(x_offset_reg);
        a_yh_next    = NH_BITS'({in_data.row, {COORD_FRAC{1'b0}}}) + NH_BITS'(y_offset_reg);
        ws_ext       = PROD_BITS'(w_scale_reg);
        disp_ext     = PROD_BITS'({1'b0, in_data.disparity});
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_xh_reg         <= a_xh_next;
            a_yh_reg         <= a_yh_next;
            a_prod_reg       <= ws_ext * disp_ext;
            a_side_reg.red   <= in_data.red;
            a_side_reg.green <= in_data.green;
            a_side_reg.blue  <= in_data.blue;
            a_side_reg.wzero <= 1'b0;
        end
    end

    // stage b: complete W
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_xh_reg   <= a_xh_reg;
            b_yh_reg   <= a_yh_reg;
            b_zh_reg   <= NH_BITS'(focal_reg);
            b_w_reg    <= W_BITS'(a_prod_reg) + W_BITS'(w_offset_reg);
            b_side_reg <= a_side_reg;
        end
    end

    // three divider lanes sharing one denominator
    always_comb
    begin
        div_x_in.num = b_xh_reg;
        div_x_in.den = b_w_reg;
        div_y_in.num = b_yh_reg;
        div_y_in.den = b_w_reg;
        div_z_in.num = b_zh_reg;
        div_z_in.den = b_w_reg;
    end

    d2p_div u_div_x (
        .clk     (clk),
        .advance (advance),
        .din     (div_x_in),
        .dout    (div_x_out)
    );

    d2p_div u_div_y (
        .clk     (clk),
        .advance (advance),
        .din     (div_y_in),
        .dout    (div_y_out)
    );

    d2p_div u_div_z (
        .clk     (clk),
        .advance (advance),
        .din     (div_z_in),
        .dout    (div_z_out)
    );

    // zero-W flag joins the colour
    always_comb
    begin
        c_side_next       = b_side_reg;
        c_side_next.wzero = (b_w_reg == '0);
    end

    // colour and zero-W flag ride alongside the dividers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_side_reg[1] <= c_side_next;
            for (int k = 2; k <= DIV_LAT; k++)
            begin
                c_side_reg[k] <= c_side_reg[k-1];
            end
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 1; k <= DIV_LAT; k++)
            begin
                c_valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg[1] <= b_valid_reg;
            for (int k = 2; k <= DIV_LAT; k++)
            begin
                c_valid_reg[k] <= c_valid_reg[k-1];
            end
            out_valid_reg <= c_valid_reg[DIV_LAT];
        end
    end

    // result assembly, zero W forces a flagged origin
    always_comb
    begin
        out_data_next.out_red   = c_side_reg[DIV_LAT].red;
        out_data_next.out_green = c_side_reg[DIV_LAT].green;
        out_data_next.out_blue  = c_side_reg[DIV_LAT].blue;
        if (c_side_reg[DIV_LAT].wzero)
        begin
            out_data_next.point_x   = '0;
            out_data_next.point_y   = '0;
            out_data_next.point_z   = '0;
            out_data_next.saturated = 1'b1;
        end
        else
        begin
            out_data_next.point_x   = div_x_out.quot;
            out_data_next.point_y   = div_y_out.quot;
            out_data_next.point_z   = div_z_out.quot;
            out_data_next.saturated = div_x_out.clamped || div_y_out.clamped ||
                                      div_z_out.clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[dv/disparity_to_point_reprojection_top_tb.sv]
`timescale 1ns / 1ps

module disparity_to_point_reprojection_top_tb;

    import d2p_pkg::*;

    // pipeline depth of the block, and the two register indexes it does not decode
    localparam int PIPE_LAT     = DIV_LAT + 3;
    localparam int SETTLE_LIMIT = 5000;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    pixel_t                    in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    point_t                    out_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_wdata = '0;

    // register shadow used for prediction
    bit                         cfg_enable;
    logic signed [CFG_BITS-1:0] cfg_x_offset;
    logic signed [CFG_BITS-1:0] cfg_y_offset;
    logic signed [CFG_BITS-1:0] cfg_focal;
    logic signed [CFG_BITS-1:0] cfg_w_scale;
    logic signed [CFG_BITS-1:0] cfg_w_offset;

    pixel_t pixel_q[$];
    point_t point_q[$];
    point_t next_point;

    int src_wait;
    int src_burst;
    bit src_calm;
    int sink_wait;
    int sink_burst;
    bit sink_calm;

    int errors;
    int n_pixels;
    int n_points;
    int n_saturated;
    int n_settings;

    disparity_to_point_reprojection_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // append one pixel to the pending queue
    function automatic void add_pixel(input pixel_t px);
        pixel_q.insert(pixel_q.size(), px);
    endfunction

    // expected point for one pixel; returns 0 when the pixel yields no point
    function automatic bit reproject_pixel(input pixel_t px, output point_t pt);
        longint num [3];
        longint w;
        longint q;
        logic signed [POINT_BITS-1:0] coord [3];
        bit clamped;
        pt = '0;
        if (!cfg_enable || px.disparity < MIN_DISP)
            return 1'b0;
        num[0] = longint'(px.col) * 65536 + longint'(cfg_x_offset);
        num[1] = longint'(px.row) * 65536 + longint'(cfg_y_offset);
        num[2] = longint'(cfg_focal);
        w = longint'(cfg_w_scale) * longint'(px.disparity) + longint'(cfg_w_offset);
        clamped = (w == 0);
        for (int i = 0; i < 3; i++)
        begin
            coord[i] = '0;
            if (w != 0)
            begin
                q = (num[i] * 64'sd16777216) / w;
                if (q > longint'(POINT_MAX))
                begin
                    coord[i] = POINT_MAX;
                    clamped = 1'b1;
                end
                else if (q < longint'(POINT_MIN))
                begin
                    coord[i] = POINT_MIN;
                    clamped = 1'b1;
                end
                else
                    coord[i] = q[POINT_BITS-1:0];
            end
        end
        pt.point_x   = coord[0];
        pt.point_y   = coord[1];
        pt.point_z   = coord[2];
        pt.out_red   = px.red;
        pt.out_green = px.green;
        pt.out_blue  = px.blue;
        pt.saturated = clamped;
        return 1'b1;
    endfunction

    // wait before the next transfer: bursts of back-to-back items alternate with random gaps
    function automatic int draw_wait(inout int burst, inout bit calm);
        if (burst == 0)
        begin
            burst = $urandom_range(8, 60);
            calm  = ($urandom_range(0, 3) == 0);
        end
        burst--;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic void report_field(input string name, input longint want,
                                         input longint got);
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        errors++;
    endfunction

    function automatic void compare_point(input point_t want, input point_t got);
        if (got.point_x !== want.point_x)
            report_field("point_x", want.point_x, got.point_x);
        if (got.point_y !== want.point_y)
            report_field("point_y", want.point_y, got.point_y);
        if (got.point_z !== want.point_z)
            report_field("point_z", want.point_z, got.point_z);
        if (got.out_red !== want.out_red)
            report_field("out_red", want.out_red, got.out_red);
        if (got.out_green !== want.out_green)
            report_field("out_green", want.out_green, got.out_green);
        if (got.out_blue !== want.out_blue)
            report_field("out_blue", want.out_blue, got.out_blue);
        if (got.saturated !== want.saturated)
            report_field("saturated", want.saturated, got.saturated);
    endfunction

    // pixel driver: presents queued pixels, predicts the point on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                n_pixels++;
                if (reproject_pixel(in_data, next_point))
                begin
                    point_q.insert(point_q.size(), next_point);
                    if (next_point.saturated)
                        n_saturated++;
                end
            end
            if (src_wait > 0)
            begin
                src_wait--;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pixel_q.pop_front();
                src_wait = draw_wait(src_burst, src_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // point monitor: checks each transfer against the oldest expected point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                n_points++;
                if (point_q.size() == 0)
                begin
                    $display("%0t unexpected point: expected none, got %p", $time, out_data);
                    errors++;
                end
                else
                    compare_point(point_q.pop_front(), out_data);
                sink_wait = draw_wait(sink_burst, sink_calm);
            end
            else if (sink_wait > 0)
                sink_wait--;
            out_ready <= (sink_wait == 0);
        end
    end

    // one register write, mirrored into the shadow
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        unique case (idx)
            REG_POINT_ENABLE: cfg_enable   = val[0];
            REG_X_OFFSET:     cfg_x_offset = val;
            REG_Y_OFFSET:     cfg_y_offset = val;
            REG_FOCAL:        cfg_focal    = val;
            REG_W_SCALE:      cfg_w_scale  = val;
            REG_W_OFFSET:     cfg_w_offset = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input bit en, input logic [CFG_BITS-1:0] xo,
                               input logic [CFG_BITS-1:0] yo, input logic [CFG_BITS-1:0] f,
                               input logic [CFG_BITS-1:0] ws, input logic [CFG_BITS-1:0] wo);
        // undecoded indexes now and then, these must change nothing
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_FOCAL, f);
        write_reg(REG_W_SCALE, ws);
        write_reg(REG_W_OFFSET, wo);
        // only bit 0 of the enable word counts
        write_reg(REG_POINT_ENABLE, {31'($urandom), en});
        n_settings++;
        @(negedge clk);
    endtask

    // let every queued pixel go in and every expected point come out
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        // sampled mid-cycle so the driver's updates at the edge are settled
        while (pixel_q.size() != 0 || in_valid)
            @(negedge clk);
        while (point_q.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (point_q.size() != 0)
        begin
            $display("%0t missing points: expected %0d more, got none", $time, point_q.size());
            errors++;
            point_q.delete();
        end
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    function automatic pixel_t pixel_at(input int c, input int r, input int d, input int red,
                                        input int green, input int blue);
        pixel_t px;
        px.col       = c[COORD_BITS-1:0];
        px.row       = r[COORD_BITS-1:0];
        px.disparity = d[DISP_BITS-1:0];
        px.red       = red[COLOR_BITS-1:0];
        px.green     = green[COLOR_BITS-1:0];
        px.blue      = blue[COLOR_BITS-1:0];
        return px;
    endfunction

    // mostly valid disparities; a share hits the zero-W disparity or falls below the minimum
    function automatic pixel_t random_pixel(input bit aim_zero, input int zero_disp);
        int pick;
        int d;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            d = $urandom_range(0, 1);
        else if (pick < 5 && aim_zero)
            d = zero_disp;
        else if (pick == 5)
            d = ($urandom_range(0, 1) != 0) ? 255 : 2;
        else
            d = $urandom_range(2, 255);
        return pixel_at($urandom_range(0, 2047), $urandom_range(0, 2047), d,
                        $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // register value: mostly plausible, sometimes an extreme or raw noise
    function automatic logic [CFG_BITS-1:0] pick_reg(input logic [CFG_BITS-1:0] typical);
        unique case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom;
            default: return typical;
        endcase
    endfunction

    // stimulus sequence
    initial
    begin
        bit                  en;
        bit                  aim_zero;
        int                  zero_disp;
        logic [CFG_BITS-1:0] ws;
        logic [CFG_BITS-1:0] wo;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset: points disabled, nothing comes out
        add_pixel(pixel_at(2047, 2047, 255, 255, 255, 255));
        add_pixel(pixel_at(0, 0, 2, 0, 0, 0));
        drain_and_settle();

        // undecoded indexes, then a plausible camera
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        load_config(1'b1, 32'hfc00_0000, 32'hfe00_0000, 32'h02bc_0000, 32'h0200_0000, '0);
        add_pixel(pixel_at(0, 0, 0, 255, 0, 255));
        add_pixel(pixel_at(0, 0, 1, 0, 255, 0));
        add_pixel(pixel_at(0, 0, 2, 8'h55, 8'haa, 8'h55));
        add_pixel(pixel_at(1, 1, 3, 8'haa, 8'h55, 8'haa));
        add_pixel(pixel_at(1024, 512, 255, 255, 255, 255));
        add_pixel(pixel_at(2047, 2047, 2, 0, 0, 0));
        add_pixel(pixel_at(2047, 0, 255, 1, 2, 3));
        add_pixel(pixel_at(0, 2047, 128, 128, 64, 32));
        add_pixel(pixel_at(1365, 682, 85, 170, 85, 170));
        drain_and_settle();

        // W reaches zero at disparity 2
        load_config(1'b1, 32'hfc00_0000, 32'hfe00_0000, 32'h02bc_0000, 32'h0200_0000,
                    32'hfc00_0000);
        add_pixel(pixel_at(700, 300, 2, 10, 20, 30));
        add_pixel(pixel_at(700, 300, 3, 30, 20, 10));
        drain_and_settle();

        // tiny W: every coordinate clamps high or low
        load_config(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, '0);
        add_pixel(pixel_at(2047, 0, 2, 255, 0, 0));
        add_pixel(pixel_at(0, 2047, 255, 0, 255, 0));
        drain_and_settle();

        // all registers at the negative extreme, then at the positive one
        load_config(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000);
        add_pixel(pixel_at(0, 2047, 2, 0, 0, 255));
        add_pixel(pixel_at(2047, 0, 255, 255, 255, 0));
        drain_and_settle();
        load_config(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff);
        add_pixel(pixel_at(2047, 2047, 2, 1, 1, 1));
        add_pixel(pixel_at(0, 0, 255, 254, 254, 254));
        drain_and_settle();

        // random settings, each followed by a batch of random pixels
        for (int p = 0; p < 10; p++)
        begin
            en        = ($urandom_range(0, 7) != 0);
            aim_zero  = ($urandom_range(0, 3) == 0);
            zero_disp = $urandom_range(2, 255);
            ws = pick_reg(32'($urandom_range(1 << 20, 1 << 26)));
            wo = pick_reg(32'($urandom_range(0, 1 << 25) - (1 << 24)));
            if (aim_zero)
            begin
                ws = 32'($urandom_range(1, 8000000));
                wo = 32'(0 - ws * zero_disp);
            end
            load_config(en, pick_reg(32'(0 - $urandom_range(0, 2047) * 65536)),
                        pick_reg(32'(0 - $urandom_range(0, 2047) * 65536)),
                        pick_reg(32'($urandom_range(100, 3000) * 65536)), ws, wo);
            for (int i = 0; i < 125; i++)
                add_pixel(random_pixel(aim_zero, zero_disp));
            drain_and_settle();
        end

        $display("run covered %0d pixels under %0d register settings", n_pixels, n_settings);
        $display("%0d points checked, %0d of them saturated, %0d mismatches",
                 n_points, n_saturated, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/d2p_pkg.sv
src/d2p_div.sv
src/disparity_to_point_reprojection_top.sv
dv/disparity_to_point_reprojection_top_tb.sv
